### design/pcbd_pkg.sv
// pcbd_pkg: shared types, constants and helpers of the prefix code bit decoder
// used by pcbd_table and prefix_code_bit_decoder; depends on nothing
package pcbd_pkg;

   localparam int SYMBOL_COUNT_DEF  = 256;
   localparam int MAX_CODE_BITS_DEF = 16;

   localparam int ACTION_W    = 2;
   localparam int SYM_W       = 8;
   localparam int CODE_W      = 16;
   localparam int LEN_FIELD_W = 5;

   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DECODE = 2'd2;

   localparam logic STATUS_MATCH    = 1'b0;
   localparam logic STATUS_OVERFLOW = 1'b1;

   typedef struct packed {
      logic [ACTION_W-1:0]    action;
      logic [SYM_W-1:0]       entry_symbol;
      logic [CODE_W-1:0]      entry_code;
      logic [LEN_FIELD_W-1:0] entry_length;
      logic                   code_bit;
   } req_type;

   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             status;
   } rsp_type;

   // table write from the sequencer
   typedef struct packed {
      logic                   valid;
      logic                   wr_en;
      logic [SYM_W-1:0]       addr;
      logic [LEN_FIELD_W-1:0] len;
      logic [CODE_W-1:0]      bits;
   } tbl_cmd_type;

   // registered table read data
   typedef struct packed {
      logic                   valid;
      logic [LEN_FIELD_W-1:0] len;
      logic [CODE_W-1:0]      bits;
   } tbl_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_WIPE = 3'b100
   } state_type;

   function automatic logic [CODE_W-1:0] code_mask(input logic [LEN_FIELD_W-1:0] len);
      logic [CODE_W:0] one_hot;
      one_hot = (CODE_W+1)'(1) << len;
      if (len >= LEN_FIELD_W'(CODE_W)) begin
         return '1;
      end
      return CODE_W'(one_hot - (CODE_W+1)'(1));
   endfunction

endpackage

### design/pcbd_ram.sv
// pcbd_ram: generic single-write, single-read synchronous ram with registered read
// depends on nothing
module pcbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/pcbd_table.sv
// pcbd_table: code table, one ram word per entry holding valid flag, length and code
// depends on pcbd_pkg and pcbd_ram
module pcbd_table #(
   parameter int SYMBOL_COUNT = pcbd_pkg::SYMBOL_COUNT_DEF
) (
   input  logic                            clock,
   input  pcbd_pkg::tbl_cmd_type           cmd,
   input  logic                            rd_en,
   input  logic [$clog2(SYMBOL_COUNT)-1:0] rd_addr,
   output pcbd_pkg::tbl_entry_type         rd_entry
);

   localparam int IDX_W  = $clog2(SYMBOL_COUNT);
   localparam int DATA_W = 1 + pcbd_pkg::LEN_FIELD_W + pcbd_pkg::CODE_W;

   logic [IDX_W-1:0]  wr_addr;
   logic [DATA_W-1:0] rd_data;

   assign wr_addr = cmd.addr[IDX_W-1:0];

   pcbd_ram #(
      .WIDTH (DATA_W),
      .DEPTH (SYMBOL_COUNT)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (wr_addr),
      .wr_data ({cmd.valid, cmd.len, cmd.bits}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_entry.valid = rd_data[DATA_W-1];
   assign rd_entry.len   = rd_data[DATA_W-2:pcbd_pkg::CODE_W];
   assign rd_entry.bits  = rd_data[pcbd_pkg::CODE_W-1:0];

endmodule

### design/prefix_code_bit_decoder.sv
// prefix_code_bit_decoder: one-bit-per-transfer prefix code decoder, top level
// depends on pcbd_pkg, pcbd_table and pcbd_ram
//
// A transfer is taken when start is high and busy is low. A load never raises
// busy. A clear, and likewise the end of reset, runs a clearing pass that marks
// every entry of the table memory invalid, one entry per cycle, with busy high
// throughout. A decode transfer shifts the bit into the accumulator, then
// walks the entry memory through its single read port, one entry per cycle
// starting at the lowest symbol, with busy high until an entry matches or the
// last entry has been checked. A result appears on rsp_data with rsp_valid
// high for exactly one cycle, in the cycle busy falls; it cannot be held off,
// so it must be taken then. A decode bit that neither matches nor fills the
// accumulator to MAX_CODE_BITS gives no result.
module prefix_code_bit_decoder #(
   parameter int SYMBOL_COUNT  = pcbd_pkg::SYMBOL_COUNT_DEF,
   parameter int MAX_CODE_BITS = pcbd_pkg::MAX_CODE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  pcbd_pkg::req_type req_data,
   output logic              busy,
   output logic              rsp_valid,
   output pcbd_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(SYMBOL_COUNT);
   localparam int ACC_W = MAX_CODE_BITS;
   localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);
   localparam int CLW   = (LEN_W > pcbd_pkg::LEN_FIELD_W) ? LEN_W : pcbd_pkg::LEN_FIELD_W;
   localparam int CBW   = (ACC_W > pcbd_pkg::CODE_W) ? ACC_W : pcbd_pkg::CODE_W;
   localparam logic [IDX_W-1:0]          LAST_IDX  = IDX_W'(SYMBOL_COUNT - 1);
   localparam logic [LEN_W-1:0]          LEN_LIMIT = LEN_W'(MAX_CODE_BITS);
   localparam logic [pcbd_pkg::SYM_W:0]  SYM_LIMIT = (pcbd_pkg::SYM_W + 1)'(SYMBOL_COUNT);

   pcbd_pkg::state_type     state_ff;
   pcbd_pkg::state_type     state_in;
   logic [IDX_W-1:0]        chk_ff;
   logic [IDX_W-1:0]        chk_in;
   logic [ACC_W-1:0]        acc_bits_ff;
   logic [ACC_W-1:0]        acc_bits_in;
   logic [LEN_W-1:0]        acc_len_ff;
   logic [LEN_W-1:0]        acc_len_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   pcbd_pkg::rsp_type       rsp_ff;
   pcbd_pkg::rsp_type       rsp_in;
   pcbd_pkg::tbl_cmd_type   tbl_cmd;
   pcbd_pkg::tbl_entry_type tbl_rd;
   logic                    rd_en;
   logic [IDX_W-1:0]        rd_addr;
   logic                    accept;
   logic                    match;

   assign busy   = (state_ff != pcbd_pkg::ST_IDLE);
   assign accept = start && !busy;

   assign match = tbl_rd.valid
               && (CLW'(tbl_rd.len) == CLW'(acc_len_ff))
               && (CBW'(tbl_rd.bits) == CBW'(acc_bits_ff));

   always_comb begin
      state_in     = state_ff;
      chk_in       = chk_ff;
      acc_bits_in  = acc_bits_ff;
      acc_len_in   = acc_len_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      tbl_cmd      = '0;
      rd_en        = 1'b0;
      rd_addr      = IDX_W'(chk_ff + 1'b1);
      case (state_ff)
         pcbd_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_data.action)
                  pcbd_pkg::ACT_CLEAR: begin
                     acc_bits_in = '0;
                     acc_len_in  = '0;
                     chk_in      = '0;
                     state_in    = pcbd_pkg::ST_WIPE;
                  end
                  pcbd_pkg::ACT_LOAD: begin
                     if ({1'b0, req_data.entry_symbol} < SYM_LIMIT) begin
                        tbl_cmd.valid = 1'b1;
                        tbl_cmd.wr_en = 1'b1;
                        tbl_cmd.addr  = req_data.entry_symbol;
                        tbl_cmd.len   = req_data.entry_length;
                        tbl_cmd.bits  = req_data.entry_code
                                      & pcbd_pkg::code_mask(req_data.entry_length);
                     end
                  end
                  pcbd_pkg::ACT_DECODE: begin
                     acc_bits_in = ACC_W'({acc_bits_ff, req_data.code_bit});
                     acc_len_in  = LEN_W'(acc_len_ff + 1'b1);
                     rd_en       = 1'b1;
                     rd_addr     = '0;
                     chk_in      = '0;
                     state_in    = pcbd_pkg::ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         pcbd_pkg::ST_SCAN: begin
            rd_en = (chk_ff != LAST_IDX);
            if (match) begin
               rsp_valid_in  = 1'b1;
               rsp_in.symbol = pcbd_pkg::SYM_W'(chk_ff);
               rsp_in.status = pcbd_pkg::STATUS_MATCH;
               acc_bits_in   = '0;
               acc_len_in    = '0;
               state_in      = pcbd_pkg::ST_IDLE;
            end else if (chk_ff == LAST_IDX) begin
               state_in = pcbd_pkg::ST_IDLE;
               if (acc_len_ff >= LEN_LIMIT) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in.symbol = '0;
                  rsp_in.status = pcbd_pkg::STATUS_OVERFLOW;
                  acc_bits_in   = '0;
                  acc_len_in    = '0;
               end
            end else begin
               chk_in = IDX_W'(chk_ff + 1'b1);
            end
         end
         pcbd_pkg::ST_WIPE: begin
            // one entry marked invalid per cycle
            tbl_cmd.wr_en = 1'b1;
            tbl_cmd.addr  = pcbd_pkg::SYM_W'(chk_ff);
            if (chk_ff == LAST_IDX) begin
               state_in = pcbd_pkg::ST_IDLE;
            end else begin
               chk_in = IDX_W'(chk_ff + 1'b1);
            end
         end
         default: begin
            state_in = pcbd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcbd_pkg::ST_WIPE;
         chk_ff       <= '0;
         acc_bits_ff  <= '0;
         acc_len_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_ff       <= chk_in;
         acc_bits_ff  <= acc_bits_in;
         acc_len_ff   <= acc_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // table writes never happen during a scan, so the scan never races a write
   pcbd_table #(
      .SYMBOL_COUNT (SYMBOL_COUNT)
   ) u_table (
      .clock    (clock),
      .cmd      (tbl_cmd),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (tbl_rd)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == pcbd_pkg::ST_IDLE))
      else $error("result strobe while scan still running");

   a_acc_clear_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (acc_len_ff == '0) && (acc_bits_ff == '0))
      else $error("accumulator not cleared after result");

   a_acc_len_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pcbd_pkg::ST_IDLE) |-> (acc_len_ff < LEN_LIMIT))
      else $error("accumulator length reached limit while idle");

   a_busy_from_transfer: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(accept && ((req_data.action == pcbd_pkg::ACT_DECODE)
                                    || (req_data.action == pcbd_pkg::ACT_CLEAR))))
      else $error("busy raised without a decode or clear transfer");
`endif

endmodule
